FILE: rtl/core/pli_pkg.sv
// Package with the request and result types and the codes of the positional list.
`timescale 1ns / 1ps

package pli_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_EMPTY    = 2'd2;
  localparam logic [1:0] STATUS_PAST_END = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic [5:0]         position;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [6:0]         entry_count;
  } out_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_READ
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_GATHER
  } state_t;

endpackage

FILE: rtl/core/pli_cell.sv
// One storage cell of the list chain that shifts, holds or offers its entry.
`timescale 1ns / 1ps

module pli_cell #(
  parameter int IW    = 6,
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  pli_pkg::cell_op_t  cmd_op,
  input  logic [IW-1:0]      cmd_pos,
  input  logic signed [31:0] cmd_value,
  input  logic signed [31:0] left_data,
  input  logic signed [31:0] right_data,
  output logic signed [31:0] data,
  output logic signed [31:0] read_word
);

  localparam logic [IW-1:0] MY_INDEX = IW'(INDEX);

  logic signed [31:0] data_next;

  always_comb begin
    data_next = data;
    case (cmd_op)
      pli_pkg::CELL_INSERT: begin
        if (MY_INDEX == cmd_pos) begin
          data_next = cmd_value;
        end else if (MY_INDEX > cmd_pos) begin
          data_next = left_data;
        end
      end
      pli_pkg::CELL_DELETE: begin
        if (MY_INDEX >= cmd_pos) begin
          data_next = right_data;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    if (cmd_op == pli_pkg::CELL_READ && MY_INDEX == cmd_pos) begin
      read_word <= data;
    end else begin
      read_word <= '0;
    end
  end

endmodule

FILE: rtl/core/positional_list_insert_delete.sv
// Top level of the positional list: request checks, command broadcast and result gather.
// An accepted request is registered as a cell command, the cells act on it and register any read word,
// and the gathered result is loaded into the output register once the output is not stalled.
// A new request waits until the previous result is loaded, and while out_stall holds that result.
// Reset empties the list and drops any held result; cell contents stay undefined.
`timescale 1ns / 1ps

module positional_list_insert_delete #(
  parameter int DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  pli_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output pli_pkg::out_t  out_data
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = (LW > 6) ? LW : 7;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  pli_pkg::state_t   state, state_next;
  logic [LW-1:0]     len, len_next;
  pli_pkg::cell_op_t cmd_op, cmd_op_next;
  logic [IW-1:0]     cmd_pos, cmd_pos_next;
  logic signed [31:0] cmd_value;
  logic [1:0]        res_status, res_status_next;
  logic              out_valid_next;
  logic              accept;
  logic              load_out;
  logic [CW-1:0]     len_ext;
  logic [CW-1:0]     pos_ext;
  logic [CW-1:0]     pos_clamp;
  logic [CW-1:0]     count_ext;
  logic signed [31:0] gathered;

  logic signed [31:0] cell_data [DEPTH];
  logic signed [31:0] cell_read [DEPTH];

  assign in_stall = (state != pli_pkg::ST_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign len_ext  = CW'(len);
  assign pos_ext  = CW'(in_data.position);

  always_comb begin
    len_next        = len;
    cmd_op_next     = pli_pkg::CELL_HOLD;
    cmd_pos_next    = cmd_pos;
    res_status_next = res_status;
    pos_clamp       = pos_ext;
    if (accept) begin
      res_status_next = pli_pkg::STATUS_OK;
      unique case (in_data.operation)
        pli_pkg::OP_INSERT: begin
          if (len_ext >= DEPTH_C) begin
            res_status_next = pli_pkg::STATUS_FULL;
          end else begin
            if (pos_ext > len_ext) begin
              pos_clamp = len_ext;
            end
            cmd_op_next  = pli_pkg::CELL_INSERT;
            cmd_pos_next = pos_clamp[IW-1:0];
            len_next     = len + LW'(1);
          end
        end
        pli_pkg::OP_DELETE: begin
          if (len == '0) begin
            res_status_next = pli_pkg::STATUS_EMPTY;
          end else if (pos_ext >= len_ext) begin
            res_status_next = pli_pkg::STATUS_PAST_END;
          end else begin
            cmd_op_next  = pli_pkg::CELL_DELETE;
            cmd_pos_next = pos_ext[IW-1:0];
            len_next     = len - LW'(1);
          end
        end
        pli_pkg::OP_READ: begin
          if (len == '0) begin
            res_status_next = pli_pkg::STATUS_EMPTY;
          end else begin
            if (pos_ext >= len_ext) begin
              pos_clamp = len_ext - CW'(1);
            end
            cmd_op_next  = pli_pkg::CELL_READ;
            cmd_pos_next = pos_clamp[IW-1:0];
          end
        end
        default: res_status_next = pli_pkg::STATUS_OK;
      endcase
    end
  end

  always_comb begin
    state_next     = state;
    load_out       = 1'b0;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      pli_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = pli_pkg::ST_EXEC;
        end
      end
      pli_pkg::ST_EXEC: begin
        state_next = pli_pkg::ST_GATHER;
      end
      pli_pkg::ST_GATHER: begin
        if (!(out_valid && out_stall)) begin
          load_out       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = pli_pkg::ST_IDLE;
        end
      end
      default: state_next = pli_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pli_pkg::ST_IDLE;
      len       <= '0;
      cmd_op    <= pli_pkg::CELL_HOLD;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      len       <= len_next;
      cmd_op    <= cmd_op_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_pos    <= cmd_pos_next;
    res_status <= res_status_next;
    if (accept) begin
      cmd_value <= in_data.value;
    end
  end

  generate
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [31:0] left_data;
      logic signed [31:0] right_data;
      if (g == 0) begin : g_first
        assign left_data = '0;
      end else begin : g_inner_left
        assign left_data = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign right_data = '0;
      end else begin : g_inner_right
        assign right_data = cell_data[g+1];
      end
      pli_cell #(
        .IW    (IW),
        .INDEX (g)
      ) u_cell (
        .clk        (clk),
        .cmd_op     (cmd_op),
        .cmd_pos    (cmd_pos),
        .cmd_value  (cmd_value),
        .left_data  (left_data),
        .right_data (right_data),
        .data       (cell_data[g]),
        .read_word  (cell_read[g])
      );
    end
  endgenerate

  always_comb begin
    gathered = '0;
    for (int i = 0; i < DEPTH; i++) begin
      gathered = gathered | cell_read[i];
    end
  end

  assign count_ext = CW'(len);

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.read_value  <= gathered;
      out_data.status      <= res_status;
      out_data.entry_count <= count_ext[6:0];
    end
  end

endmodule

FILE: tb/sv/positional_list_insert_delete_test.sv
// Self-checking testbench for the positional list with directed and random requests.
`timescale 1ns / 1ps

module positional_list_insert_delete_test;

  localparam int DEPTH = 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 900;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 12;

  typedef enum int {
    PHASE_FILL,
    PHASE_DRAIN,
    PHASE_MIXED
  } phase_t;

  typedef struct packed {
    pli_pkg::in_t  req;
    logic          typed;
    pli_pkg::out_t res;
  } row_t;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_stall;
  pli_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  pli_pkg::out_t out_data;

  logic signed [31:0] shadow_vals [DEPTH];
  int                 shadow_len;
  row_t               dir_rows [$];
  pli_pkg::out_t      expected_results [$];
  int                 accepted;
  int                 fail_count;
  int                 idle_cycles;

  positional_list_insert_delete #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic pli_pkg::out_t apply_list_op(input pli_pkg::in_t req);
    pli_pkg::out_t res;
    int            p;
    int            i;
    res = '0;
    res.status = pli_pkg::STATUS_OK;
    p = req.position;
    case (req.operation)
      pli_pkg::OP_INSERT: begin
        if (shadow_len >= DEPTH) begin
          res.status = pli_pkg::STATUS_FULL;
        end else begin
          if (p > shadow_len) p = shadow_len;
          for (i = shadow_len; i > p; i--) shadow_vals[i] = shadow_vals[i - 1];
          shadow_vals[p] = req.value;
          shadow_len++;
        end
      end
      pli_pkg::OP_DELETE: begin
        if (shadow_len == 0) begin
          res.status = pli_pkg::STATUS_EMPTY;
        end else if (p >= shadow_len) begin
          res.status = pli_pkg::STATUS_PAST_END;
        end else begin
          for (i = p; i < shadow_len - 1; i++) shadow_vals[i] = shadow_vals[i + 1];
          shadow_len--;
        end
      end
      pli_pkg::OP_READ: begin
        if (shadow_len == 0) begin
          res.status = pli_pkg::STATUS_EMPTY;
        end else begin
          if (p > shadow_len - 1) p = shadow_len - 1;
          res.read_value = shadow_vals[p];
        end
      end
      default: begin
      end
    endcase
    res.entry_count = 7'(shadow_len);
    return res;
  endfunction

  task automatic add_row(input logic [1:0] op, input int pos, input logic [31:0] val,
                         input bit typed, input logic [31:0] rd, input logic [1:0] st,
                         input int cnt);
    row_t row;
    row.req.operation = op;
    row.req.position = 6'(pos);
    row.req.value = val;
    row.typed = typed;
    row.res.read_value = rd;
    row.res.status = st;
    row.res.entry_count = 7'(cnt);
    dir_rows.push_back(row);
  endtask

  task automatic check_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expv, actv);
    end
  endtask

  always @(posedge clk) begin : track
    pli_pkg::out_t want;
    bit            moved;
    if (!rst) begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        want = apply_list_op(in_data);
        if (accepted < dir_rows.size() && dir_rows[accepted].typed) begin
          want = dir_rows[accepted].res;
        end
        expected_results.push_back(want);
        accepted++;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: expected none, actual %p", $time, out_data);
        end else begin
          want = expected_results.pop_front();
          check_field("read_value", want.read_value, out_data.read_value);
          check_field("status", want.status, out_data.status);
          check_field("entry_count", want.entry_count, out_data.entry_count);
        end
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress: expected %0d more results, actual none", $time,
                 expected_results.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : stall_results
    int  seg_len;
    int  mode;
    bit  held;
    out_stall <= 1'b0;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      seg_len = $urandom_range(20, 200);
      mode = $urandom_range(0, 3);
      if (!held && accepted >= dir_rows.size() + 150) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      for (int j = 0; j < seg_len; j++) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((j % 4) < 2);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : main
    pli_pkg::in_t req;
    int           total;
    int           burst_left;
    int           gap;
    int           phase_left;
    int           phase_no;
    phase_t       phase_kind;
    int           ins_pct;
    int           del_pct;
    int           r;
    int           top;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    shadow_len = 0;
    accepted = 0;
    fail_count = 0;
    idle_cycles = 0;
    burst_left = 0;
    phase_left = 0;
    phase_no = 0;
    phase_kind = PHASE_FILL;

    add_row(pli_pkg::OP_READ,   5,  32'h0000_0000, 1, 32'h0000_0000,
            pli_pkg::STATUS_EMPTY, 0);
    add_row(pli_pkg::OP_DELETE, 0,  32'h0000_0000, 1, 32'h0000_0000,
            pli_pkg::STATUS_EMPTY, 0);
    add_row(OP_UNUSED,          63, 32'hFFFF_FFFF, 1, 32'h0000_0000,
            pli_pkg::STATUS_OK, 0);
    add_row(pli_pkg::OP_INSERT, 63, 32'h7FFF_FFFF, 1, 32'h0000_0000,
            pli_pkg::STATUS_OK, 1);
    add_row(pli_pkg::OP_INSERT, 0,  32'h8000_0000, 1, 32'h0000_0000,
            pli_pkg::STATUS_OK, 2);
    add_row(pli_pkg::OP_READ,   0,  32'h1234_5678, 1, 32'h8000_0000,
            pli_pkg::STATUS_OK, 2);
    add_row(pli_pkg::OP_READ,   63, 32'h0000_0000, 1, 32'h7FFF_FFFF,
            pli_pkg::STATUS_OK, 2);
    add_row(pli_pkg::OP_DELETE, 63, 32'h0000_0000, 1, 32'h0000_0000,
            pli_pkg::STATUS_PAST_END, 2);
    add_row(pli_pkg::OP_DELETE, 2,  32'h0000_0000, 1, 32'h0000_0000,
            pli_pkg::STATUS_PAST_END, 2);
    add_row(pli_pkg::OP_INSERT, 1,  32'hFFFF_FFFF, 0, '0, pli_pkg::STATUS_OK, 0);
    add_row(pli_pkg::OP_INSERT, 2,  32'h0000_0000, 0, '0, pli_pkg::STATUS_OK, 0);
    add_row(pli_pkg::OP_READ,   1,  32'h0000_0000, 0, '0, pli_pkg::STATUS_OK, 0);
    add_row(pli_pkg::OP_DELETE, 0,  32'h0000_0000, 0, '0, pli_pkg::STATUS_OK, 0);
    add_row(pli_pkg::OP_DELETE, 1,  32'h0000_0000, 0, '0, pli_pkg::STATUS_OK, 0);
    add_row(pli_pkg::OP_READ,   0,  32'h0000_0000, 0, '0, pli_pkg::STATUS_OK, 0);
    add_row(OP_UNUSED,          0,  32'h0000_0000, 0, '0, pli_pkg::STATUS_OK, 0);
    add_row(pli_pkg::OP_INSERT, 3,  32'h5555_5555, 0, '0, pli_pkg::STATUS_OK, 0);
    add_row(pli_pkg::OP_INSERT, 0,  32'hAAAA_AAAA, 0, '0, pli_pkg::STATUS_OK, 0);
    add_row(pli_pkg::OP_READ,   2,  32'h0000_0000, 0, '0, pli_pkg::STATUS_OK, 0);
    add_row(pli_pkg::OP_DELETE, 3,  32'h0000_0000, 0, '0, pli_pkg::STATUS_OK, 0);
    add_row(pli_pkg::OP_DELETE, 0,  32'h0000_0000, 0, '0, pli_pkg::STATUS_OK, 0);
    add_row(pli_pkg::OP_DELETE, 0,  32'h0000_0000, 0, '0, pli_pkg::STATUS_OK, 0);
    add_row(pli_pkg::OP_DELETE, 0,  32'h0000_0000, 0, '0, pli_pkg::STATUS_OK, 0);
    add_row(pli_pkg::OP_READ,   0,  32'h0000_0000, 0, '0, pli_pkg::STATUS_OK, 0);
    total = dir_rows.size() + RANDOM_ITEMS;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < total; k++) begin
      if (k < dir_rows.size()) begin
        req = dir_rows[k].req;
      end else begin
        // Fill first so the full case is reached, then drain, then random phases.
        if (phase_left == 0) begin
          phase_kind = (phase_no < 2) ? phase_t'(phase_no) : phase_t'($urandom_range(0, 2));
          phase_no++;
          phase_left = (phase_kind == PHASE_FILL) ? $urandom_range(100, 140)
                                                  : $urandom_range(40, 140);
        end
        phase_left--;
        case (phase_kind)
          PHASE_FILL: begin
            ins_pct = 85;
            del_pct = 5;
          end
          PHASE_DRAIN: begin
            ins_pct = 10;
            del_pct = 75;
          end
          default: begin
            ins_pct = 35;
            del_pct = 30;
          end
        endcase
        r = $urandom_range(0, 99);
        if (r >= 98) req.operation = OP_UNUSED;
        else if (r < ins_pct) req.operation = pli_pkg::OP_INSERT;
        else if (r < ins_pct + del_pct) req.operation = pli_pkg::OP_DELETE;
        else req.operation = pli_pkg::OP_READ;
        top = (shadow_len > 63) ? 63 : shadow_len;
        req.position = $urandom_range(0, 1) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, top));
        req.value = $urandom();
      end

      if (k == dir_rows.size() + 450) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      if (burst_left > 0) burst_left--;

      in_valid <= 1'b1;
      in_data <= req;
      do @(posedge clk); while (!(in_valid && !in_stall));
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/pli_pkg.sv
rtl/core/pli_cell.sv
rtl/core/positional_list_insert_delete.sv
tb/sv/positional_list_insert_delete_test.sv
